// ----- rtl/cgr_pkg.sv -----
// Shared types, constants and the helper function of the character grid rotator.
package cgr_pkg;

  // Image store dimensions.
  localparam int MAX_ROWS = 64;
  localparam int MAX_COLS = 64;
  localparam int MAX_DIM  = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;

  // Counter width holds every row or column count up to and including the limit.
  localparam int CNT_W   = $clog2(MAX_DIM + 1);
  localparam int RIDX_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int ST_DEPTH = MAX_ROWS * MAX_COLS;
  localparam int ST_AW   = (ST_DEPTH > 1) ? $clog2(ST_DEPTH) : 1;

  localparam logic [CNT_W-1:0] ROWS_LIM = CNT_W'(MAX_ROWS);
  localparam logic [CNT_W-1:0] COLS_LIM = CNT_W'(MAX_COLS);

  // Fixed field widths.
  localparam int OP_W    = 2;
  localparam int CHAR_W  = 8;
  localparam int ANGLE_W = 9;
  localparam int DIM_W   = 7;

  localparam logic [CHAR_W-1:0]  BLANK     = 8'h20;
  localparam logic [ANGLE_W-1:0] ANGLE_90  = 9'd90;
  localparam logic [ANGLE_W-1:0] ANGLE_180 = 9'd180;
  localparam logic [ANGLE_W-1:0] ANGLE_270 = 9'd270;

  // Command queue between the front and back ends (power-of-two depth).
  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);

  // Result queue toward the output port (power-of-two depth).
  localparam int RESQ_DEPTH = 2;
  localparam int RESQ_AW    = $clog2(RESQ_DEPTH);
  localparam int RESQ_CW    = $clog2(RESQ_DEPTH + 1);

  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 2'd0,
    OP_CLOSE  = 2'd1,
    OP_READ   = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    TURN_NONE = 2'd0,
    TURN_90   = 2'd1,
    TURN_180  = 2'd2,
    TURN_270  = 2'd3
  } turn_t;

  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_READ = 1'b1
  } bk_state_t;

  typedef struct packed {
    op_t               op;
    logic [CHAR_W-1:0] chr;
    turn_t             turn;
  } cmd_t;

  typedef struct packed {
    logic [CHAR_W-1:0] chr;
    logic              row_end;
    logic              frame_end;
    logic [DIM_W-1:0]  height;
    logic [DIM_W-1:0]  width;
    logic              overflow;
  } result_t;

  // Only the three exact right angles rotate; anything else is no turn.
  function automatic turn_t turn_of(input logic [ANGLE_W-1:0] angle);
    turn_t t;
    t = TURN_NONE;
    if (angle == ANGLE_90) begin
      t = TURN_90;
    end else if (angle == ANGLE_180) begin
      t = TURN_180;
    end else if (angle == ANGLE_270) begin
      t = TURN_270;
    end
    return t;
  endfunction

endpackage

// ----- rtl/cgr_front.sv -----
// Front end: accepts requests, decodes them into commands and queues them.
module cgr_front import cgr_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic [OP_W-1:0]    in_operation,
  input  logic [CHAR_W-1:0]  in_character,
  input  logic [ANGLE_W-1:0] in_angle,
  output logic               cmd_valid,
  output cmd_t               cmd,
  input  logic               cmd_pop
);

  cmd_t                 q_mem [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [CMDQ_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CMDQ_CW-1:0]   cnt_r, cnt_nxt;
  logic                 push, pop;
  cmd_t                 cmd_in;

  // Decode the request: keep the byte only for appends, map the angle to a turn.
  always_comb begin
    cmd_in.op   = op_t'(in_operation);
    cmd_in.chr  = (op_t'(in_operation) == OP_APPEND) ? in_character : '0;
    cmd_in.turn = turn_of(in_angle);
  end

  // Queue handshake.
  assign in_full   = (cnt_r == CMDQ_CW'(CMDQ_DEPTH));
  assign cmd_valid = (cnt_r != '0);
  assign push      = in_push && !in_full;
  assign pop       = cmd_pop && cmd_valid;
  assign cmd       = q_mem[rd_ptr_r];

  // Pointer and fill count updates; pointers wrap naturally.
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + CMDQ_CW'(push) - CMDQ_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Queue storage holds payload only.
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= cmd_in;
    end
  end

endmodule

// ----- rtl/cgr_resq.sv -----
// Result queue: holds finished read results until the consumer pops them.
module cgr_resq import cgr_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    res_push,
  input  result_t res_in,
  output logic    res_full,
  output logic    res_empty,
  output result_t res_out,
  input  logic    res_pop
);

  result_t              q_mem [RESQ_DEPTH];
  logic [RESQ_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [RESQ_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [RESQ_CW-1:0]   cnt_r, cnt_nxt;
  logic                 push, pop;

  assign res_full  = (cnt_r == RESQ_CW'(RESQ_DEPTH));
  assign res_empty = (cnt_r == '0);
  assign push      = res_push && !res_full;
  assign pop       = res_pop && !res_empty;
  assign res_out   = q_mem[rd_ptr_r];

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + RESQ_CW'(push) - RESQ_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= res_in;
    end
  end

endmodule

// ----- rtl/cgr_back.sv -----
// Back end: executes queued commands against the image store and builds read results.
module cgr_back import cgr_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    cmd_valid,
  input  cmd_t    cmd,
  output logic    cmd_pop,
  input  logic    res_full,
  output logic    res_push,
  output result_t res_out
);

  // Image memories; contents are undefined until written.
  logic [CHAR_W-1:0] st_mem [ST_DEPTH];
  logic [CNT_W-1:0]  rl_mem [MAX_ROWS];
  logic [CHAR_W-1:0] st_q;
  logic [CNT_W-1:0]  rl_q;

  bk_state_t         state_r, state_nxt;
  logic [CNT_W-1:0]  row_count_r, row_count_nxt;
  logic [CNT_W-1:0]  widest_r, widest_nxt;
  logic [CNT_W-1:0]  wcol_r, wcol_nxt;
  logic [CNT_W-1:0]  rrow_r, rrow_nxt;
  logic [CNT_W-1:0]  rcol_r, rcol_nxt;
  turn_t             turn_r, turn_nxt;
  logic              pass_r, pass_nxt;
  logic              lost_r, lost_nxt;

  // Read pipeline payload, captured when a read is issued.
  logic [CNT_W-1:0]  p_col_r;
  logic              p_blank_r, p_re_r, p_fe_r;
  logic [CNT_W-1:0]  p_oh_r, p_ow_r;

  logic              st_we, rl_we, issue;
  logic [ST_AW-1:0]  st_waddr, st_raddr;
  turn_t             turn_use;
  logic [CNT_W-1:0]  oh, ow, ri, rj, src_r, src_c;
  logic              empty_img, re, fe;

  // Output geometry and clamped position for the current read.
  always_comb begin
    turn_use = pass_r ? turn_r : cmd.turn;
    if (turn_use == TURN_90 || turn_use == TURN_270) begin
      oh = widest_r;
      ow = row_count_r;
    end else begin
      oh = row_count_r;
      ow = widest_r;
    end
    empty_img = (oh == '0) || (ow == '0);
    ri = (rrow_r >= oh) ? oh - 1'b1 : rrow_r;
    rj = (rcol_r >= ow) ? ow - 1'b1 : rcol_r;
    re = empty_img || (rj == ow - 1'b1);
    fe = empty_img || (re && (ri == oh - 1'b1));
  end

  // Map the output position back to a source row and column.
  always_comb begin
    unique case (turn_use)
      TURN_90: begin
        src_r = row_count_r - 1'b1 - rj;
        src_c = ri;
      end
      TURN_180: begin
        src_r = row_count_r - 1'b1 - ri;
        src_c = widest_r - 1'b1 - rj;
      end
      TURN_270: begin
        src_r = rj;
        src_c = widest_r - 1'b1 - ri;
      end
      default: begin
        src_r = ri;
        src_c = rj;
      end
    endcase
    st_raddr = ST_AW'(src_r * MAX_COLS + src_c);
    st_waddr = ST_AW'(row_count_r * MAX_COLS + wcol_r);
  end

  // Command sequencer.
  always_comb begin
    state_nxt     = state_r;
    row_count_nxt = row_count_r;
    widest_nxt    = widest_r;
    wcol_nxt      = wcol_r;
    rrow_nxt      = rrow_r;
    rcol_nxt      = rcol_r;
    turn_nxt      = turn_r;
    pass_nxt      = pass_r;
    lost_nxt      = lost_r;
    cmd_pop       = 1'b0;
    st_we         = 1'b0;
    rl_we         = 1'b0;
    issue         = 1'b0;
    res_push      = 1'b0;
    unique case (state_r)
      BK_IDLE: begin
        if (cmd_valid) begin
          unique case (cmd.op)
            OP_APPEND: begin
              cmd_pop  = 1'b1;
              pass_nxt = 1'b0;
              rrow_nxt = '0;
              rcol_nxt = '0;
              if (row_count_r >= ROWS_LIM || wcol_r >= COLS_LIM) begin
                lost_nxt = 1'b1;
              end else begin
                st_we    = 1'b1;
                wcol_nxt = wcol_r + 1'b1;
              end
            end
            OP_CLOSE: begin
              cmd_pop  = 1'b1;
              pass_nxt = 1'b0;
              rrow_nxt = '0;
              rcol_nxt = '0;
              wcol_nxt = '0;
              if (row_count_r >= ROWS_LIM) begin
                lost_nxt = 1'b1;
              end else begin
                rl_we         = 1'b1;
                row_count_nxt = row_count_r + 1'b1;
                if (wcol_r > widest_r) begin
                  widest_nxt = wcol_r;
                end
              end
            end
            OP_CLEAR: begin
              cmd_pop       = 1'b1;
              row_count_nxt = '0;
              widest_nxt    = '0;
              wcol_nxt      = '0;
              rrow_nxt      = '0;
              rcol_nxt      = '0;
              turn_nxt      = TURN_NONE;
              pass_nxt      = 1'b0;
              lost_nxt      = 1'b0;
            end
            default: begin
              // Read: only start when the result queue can take the answer.
              if (!res_full) begin
                cmd_pop   = 1'b1;
                issue     = 1'b1;
                turn_nxt  = turn_use;
                pass_nxt  = 1'b1;
                state_nxt = BK_READ;
                if (re) begin
                  rcol_nxt = '0;
                  rrow_nxt = ri + 1'b1;
                end else begin
                  rcol_nxt = rj + 1'b1;
                  rrow_nxt = ri;
                end
                if (fe) begin
                  pass_nxt = 1'b0;
                  rrow_nxt = '0;
                  rcol_nxt = '0;
                end
              end
            end
          endcase
        end
      end
      default: begin
        // Memory data is back: hand the result over.
        res_push  = 1'b1;
        state_nxt = BK_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      row_count_r <= '0;
      widest_r    <= '0;
      wcol_r      <= '0;
      rrow_r      <= '0;
      rcol_r      <= '0;
      turn_r      <= TURN_NONE;
      pass_r      <= 1'b0;
      lost_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      row_count_r <= row_count_nxt;
      widest_r    <= widest_nxt;
      wcol_r      <= wcol_nxt;
      rrow_r      <= rrow_nxt;
      rcol_r      <= rcol_nxt;
      turn_r      <= turn_nxt;
      pass_r      <= pass_nxt;
      lost_r      <= lost_nxt;
    end
  end

  // Read pipeline payload.
  always_ff @(posedge clk) begin
    if (issue) begin
      p_col_r   <= src_c;
      p_blank_r <= empty_img;
      p_re_r    <= re;
      p_fe_r    <= fe;
      p_oh_r    <= oh;
      p_ow_r    <= ow;
    end
  end

  // Character store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (st_we) begin
      st_mem[st_waddr] <= cmd.chr;
    end
    st_q <= st_mem[st_raddr];
  end

  // Row length store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (rl_we) begin
      rl_mem[row_count_r[RIDX_W-1:0]] <= wcol_r;
    end
    rl_q <= rl_mem[src_r[RIDX_W-1:0]];
  end

  // Past the end of a short row the image reads as blank.
  always_comb begin
    res_out.chr       = (p_blank_r || (p_col_r >= rl_q)) ? BLANK : st_q;
    res_out.row_end   = p_re_r;
    res_out.frame_end = p_fe_r;
    res_out.height    = DIM_W'(p_oh_r);
    res_out.width     = DIM_W'(p_ow_r);
    res_out.overflow  = lost_r;
  end

  // An issued read delivers its result on the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    issue |=> (res_push && state_r == BK_READ))
    else $error("read issued without a result on the next cycle");

  // Fill counters never pass the store limits.
  assert property (@(posedge clk) disable iff (!rst_n)
    (row_count_r <= ROWS_LIM) && (wcol_r <= COLS_LIM) && (widest_r <= COLS_LIM))
    else $error("image counters beyond store limits");

  // Outside a pass the read position rests at the origin.
  assert property (@(posedge clk) disable iff (!rst_n)
    !pass_r |-> (rrow_r == '0 && rcol_r == '0))
    else $error("read position not at origin outside a pass");

  // No command is taken while a read result is still pending.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_READ) |-> !cmd_pop)
    else $error("command popped while a read is pending");

endmodule

// ----- rtl/char_grid_rotator_unit.sv -----
// Append, close and clear requests update the image state when the back end pops them.
// A read result passes the command queue, the registered memory read and the result queue.
// Throughput: one append, close or clear per cycle while no read is pending; a read blocks
// new commands until the registered read of the character and row-length memories returns.
// Reset clears all control state; the image memories are not cleared and need no pass.
module char_grid_rotator_unit import cgr_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic [OP_W-1:0]    in_operation,
  input  logic [CHAR_W-1:0]  in_character,
  input  logic [ANGLE_W-1:0] in_angle,
  output logic               out_empty,
  input  logic               out_pop,
  output logic [CHAR_W-1:0]  out_char,
  output logic               out_row_end,
  output logic               out_frame_end,
  output logic [DIM_W-1:0]   out_height,
  output logic [DIM_W-1:0]   out_width,
  output logic               out_overflow
);

  logic    cmd_valid, cmd_pop;
  cmd_t    cmd;
  logic    res_full, res_push;
  result_t res_in, res_head;

  // Request decode and command queue.
  cgr_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_full      (in_full),
    .in_operation (in_operation),
    .in_character (in_character),
    .in_angle     (in_angle),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cmd_pop      (cmd_pop)
  );

  // Command execution and image memories.
  cgr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_out   (res_in)
  );

  // Result queue toward the consumer.
  cgr_resq u_resq (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_push  (res_push),
    .res_in    (res_in),
    .res_full  (res_full),
    .res_empty (out_empty),
    .res_out   (res_head),
    .res_pop   (out_pop)
  );

  assign out_char      = res_head.chr;
  assign out_row_end   = res_head.row_end;
  assign out_frame_end = res_head.frame_end;
  assign out_height    = res_head.height;
  assign out_width     = res_head.width;
  assign out_overflow  = res_head.overflow;

endmodule

// ----- dv/grid_rotation_checker.sv -----
// Checker for the character grid rotator: predicts every read result and compares it.
module grid_rotation_checker import cgr_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  input  logic               in_full,
  input  logic [OP_W-1:0]    in_operation,
  input  logic [CHAR_W-1:0]  in_character,
  input  logic [ANGLE_W-1:0] in_angle,
  input  logic               out_empty,
  input  logic               out_pop,
  input  logic [CHAR_W-1:0]  out_char,
  input  logic               out_row_end,
  input  logic               out_frame_end,
  input  logic [DIM_W-1:0]   out_height,
  input  logic [DIM_W-1:0]   out_width,
  input  logic               out_overflow,
  output int                 mismatches,
  output int                 awaited,
  output int                 checked
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow copy of the image and the read cursor.
  logic [CHAR_W-1:0] img [MAX_ROWS*MAX_COLS];
  int                row_len [MAX_ROWS];
  int                rows;
  int                widest;
  int                wcol;
  int                rd_row;
  int                rd_col;
  turn_t             turn;
  bit                pass_on;
  bit                lost;

  // Read results still owed by the block, oldest first.
  result_t           awaited_chars [$];
  result_t           want;
  int                n_bad;
  int                n_checked;
  int                n_wait;

  assign mismatches = n_bad;
  assign awaited    = n_wait;
  assign checked    = n_checked;

  function automatic void stop_pass();
    pass_on = 1'b0;
    rd_row  = 0;
    rd_col  = 0;
  endfunction

  function automatic void wipe_image();
    rows   = 0;
    widest = 0;
    wcol   = 0;
    turn   = TURN_NONE;
    lost   = 1'b0;
    stop_pass();
  endfunction

  initial begin
    n_bad     = 0;
    n_checked = 0;
    n_wait    = 0;
    wipe_image();
  end

  // Advance the shadow state by one accepted request; a read queues its result.
  task automatic rotate_step(op_t op, logic [CHAR_W-1:0] ch, logic [ANGLE_W-1:0] ang);
    int                h, w, oh, ow, i, j, r, c;
    bit                re, fe;
    logic [CHAR_W-1:0] pix;
    result_t           res;
    case (op)
      OP_CLEAR: begin
        wipe_image();
      end
      OP_APPEND: begin
        stop_pass();
        if (rows >= MAX_ROWS || wcol >= MAX_COLS) begin
          lost = 1'b1;
        end else begin
          img[rows*MAX_COLS + wcol] = ch;
          wcol++;
        end
      end
      OP_CLOSE: begin
        stop_pass();
        if (rows >= MAX_ROWS) begin
          lost = 1'b1;
        end else begin
          row_len[rows] = wcol;
          if (wcol > widest) widest = wcol;
          rows++;
        end
        wcol = 0;
      end
      default: begin
        // The first read of a pass picks the turn; later reads ignore the angle.
        if (!pass_on) begin
          case (ang)
            ANGLE_90:  turn = TURN_90;
            ANGLE_180: turn = TURN_180;
            ANGLE_270: turn = TURN_270;
            default:   turn = TURN_NONE;
          endcase
          pass_on = 1'b1;
          rd_row  = 0;
          rd_col  = 0;
        end
        h = rows;
        w = widest;
        if (turn == TURN_90 || turn == TURN_270) begin
          oh = w;
          ow = h;
        end else begin
          oh = h;
          ow = w;
        end
        if (oh == 0 || ow == 0) begin
          pix = BLANK;
          re  = 1'b1;
          fe  = 1'b1;
        end else begin
          i = (rd_row >= oh) ? oh - 1 : rd_row;
          j = (rd_col >= ow) ? ow - 1 : rd_col;
          // Map the output position back to a source row and column.
          case (turn)
            TURN_90: begin
              r = h - 1 - j;
              c = i;
            end
            TURN_180: begin
              r = h - 1 - i;
              c = w - 1 - j;
            end
            TURN_270: begin
              r = j;
              c = w - 1 - i;
            end
            default: begin
              r = i;
              c = j;
            end
          endcase
          // Past the end of a short row the image reads as a space.
          pix = (r < rows && c < row_len[r]) ? img[r*MAX_COLS + c] : BLANK;
          re  = (j == ow - 1);
          fe  = re && (i == oh - 1);
          if (re) begin
            rd_col = 0;
            rd_row = i + 1;
          end else begin
            rd_col = j + 1;
            rd_row = i;
          end
        end
        if (fe) stop_pass();
        res.chr       = pix;
        res.row_end   = re;
        res.frame_end = fe;
        res.height    = oh[DIM_W-1:0];
        res.width     = ow[DIM_W-1:0];
        res.overflow  = lost;
        awaited_chars.push_back(res);
      end
    endcase
  endtask

  task automatic check_field(string name, int exp_val, int act_val);
    if (exp_val != act_val) begin
      $display("%0t ns: %s expected %0d actual %0d", $time, name, exp_val, act_val);
      n_bad++;
    end
  endtask

  // Compare popped results first, then fold in the request taken at this edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_pop && !out_empty) begin
        if (awaited_chars.size() == 0) begin
          $display("%0t ns: result expected none actual char 0x%02h", $time, out_char);
          n_bad++;
        end else begin
          want = awaited_chars.pop_front();
          check_field("out_char", want.chr, out_char);
          check_field("out_row_end", want.row_end, out_row_end);
          check_field("out_frame_end", want.frame_end, out_frame_end);
          check_field("out_height", want.height, out_height);
          check_field("out_width", want.width, out_width);
          check_field("out_overflow", want.overflow, out_overflow);
          n_checked++;
        end
      end
      if (in_push && !in_full) begin
        rotate_step(op_t'(in_operation), in_character, in_angle);
      end
      n_wait <= awaited_chars.size();
    end
  end

endmodule

// ----- dv/tb_top.sv -----
// Top of the rotator testbench: clock, reset, request stimulus, output stalls and verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import cgr_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES    = 300;
  localparam int PHASE_ITEMS    = 600;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_push = 1'b0;
  logic               in_full;
  logic [OP_W-1:0]    in_operation = '0;
  logic [CHAR_W-1:0]  in_character = '0;
  logic [ANGLE_W-1:0] in_angle = '0;
  logic               out_empty;
  logic               out_pop = 1'b0;
  logic [CHAR_W-1:0]  out_char;
  logic               out_row_end;
  logic               out_frame_end;
  logic [DIM_W-1:0]   out_height;
  logic [DIM_W-1:0]   out_width;
  logic               out_overflow;

  int mismatches;
  int awaited;
  int checked;

  // Idle odds in percent, and the long output stall handshake.
  int send_idle = 0;
  int recv_idle = 0;
  int hold_asks = 0;
  int holds_served = 0;
  int stall_left = 0;
  int quiet = 0;

  // Request counts and a rough image size used only to size the reads.
  int n_sent = 0;
  int n_reads = 0;
  int img_rows = 0;
  int img_width = 0;
  int open_cols = 0;

  always #5 clk = ~clk;

  char_grid_rotator_unit u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_operation  (in_operation),
    .in_character  (in_character),
    .in_angle      (in_angle),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_char      (out_char),
    .out_row_end   (out_row_end),
    .out_frame_end (out_frame_end),
    .out_height    (out_height),
    .out_width     (out_width),
    .out_overflow  (out_overflow)
  );

  grid_rotation_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_operation  (in_operation),
    .in_character  (in_character),
    .in_angle      (in_angle),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_char      (out_char),
    .out_row_end   (out_row_end),
    .out_frame_end (out_frame_end),
    .out_height    (out_height),
    .out_width     (out_width),
    .out_overflow  (out_overflow),
    .mismatches    (mismatches),
    .awaited       (awaited),
    .checked       (checked)
  );

  function automatic logic [CHAR_W-1:0] rnd_char();
    return CHAR_W'($urandom_range(255));
  endfunction

  // Right angles often, otherwise anything the 9-bit field can hold.
  function automatic logic [ANGLE_W-1:0] rnd_angle();
    case ($urandom_range(5))
      0:       return ANGLE_90;
      1:       return ANGLE_180;
      2:       return ANGLE_270;
      3:       return '0;
      default: return ANGLE_W'($urandom_range(511));
    endcase
  endfunction

  function automatic int frame_len();
    return (img_rows * img_width == 0) ? 1 : img_rows * img_width;
  endfunction

  // Offer one request, with random idle cycles first, and wait until it is taken.
  task automatic send(op_t op, logic [CHAR_W-1:0] ch, logic [ANGLE_W-1:0] ang);
    while ($urandom_range(99) < send_idle) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push      <= 1'b1;
    in_operation <= op;
    in_character <= ch;
    in_angle     <= ang;
    @(posedge clk);
    while (in_full) @(posedge clk);
    n_sent++;
    case (op)
      OP_CLEAR: begin
        img_rows  = 0;
        img_width = 0;
        open_cols = 0;
      end
      OP_APPEND: begin
        open_cols++;
      end
      OP_CLOSE: begin
        if (img_rows < MAX_ROWS) begin
          img_rows++;
          if (open_cols > MAX_COLS) open_cols = MAX_COLS;
          if (open_cols > img_width) img_width = open_cols;
        end
        open_cols = 0;
      end
      default: begin
        n_reads++;
      end
    endcase
  endtask

  task automatic clear_image();
    send(OP_CLEAR, rnd_char(), rnd_angle());
  endtask

  // Append rows of random length, optionally leaving a last row open.
  task automatic put_rows(int nrows, int maxcols, bit leave_open);
    int n;
    repeat (nrows) begin
      n = $urandom_range(maxcols);
      repeat (n) send(OP_APPEND, rnd_char(), rnd_angle());
      send(OP_CLOSE, rnd_char(), rnd_angle());
    end
    if (leave_open) begin
      repeat ($urandom_range(1, 3)) send(OP_APPEND, rnd_char(), rnd_angle());
    end
  endtask

  task automatic read_n(int n);
    repeat (n) send(OP_READ, rnd_char(), rnd_angle());
  endtask

  // Hand-picked requests: empty images, field extremes, latching and a reload mid-pass.
  task automatic directed_part();
    send(OP_READ, 8'h00, ANGLE_90);
    send(OP_CLOSE, 8'hFF, 9'h1FF);
    send(OP_READ, 8'hFF, 9'd0);
    clear_image();
    send(OP_APPEND, 8'h00, 9'd0);
    send(OP_APPEND, 8'hFF, 9'h1FF);
    send(OP_CLOSE, 8'h00, 9'd0);
    send(OP_APPEND, 8'h41, 9'd0);
    send(OP_CLOSE, 8'h00, 9'd0);
    send(OP_APPEND, 8'h42, 9'd0);
    send(OP_READ, 8'h00, ANGLE_90);
    send(OP_READ, 8'h00, ANGLE_180);
    send(OP_READ, 8'h00, 9'd0);
    send(OP_READ, 8'h00, ANGLE_270);
    send(OP_READ, 8'h00, ANGLE_180);
    send(OP_READ, 8'h00, 9'd0);
    send(OP_APPEND, 8'h43, 9'd0);
    send(OP_READ, 8'h00, ANGLE_270);
    send(OP_READ, 8'h00, 9'd0);
    send(OP_READ, 8'h00, 9'd0);
    send(OP_READ, 8'h00, 9'd0);
    send(OP_READ, 8'h00, 9'd359);
    send(OP_CLOSE, 8'h00, 9'd0);
    send(OP_READ, 8'h00, 9'h1FF);
  endtask

  // Mostly complete images read back in full, plus noise, reloads and overflow.
  task automatic random_phase(int quota);
    int kind;
    int goal;
    goal = n_sent + quota;
    hold_asks++;
    while (n_sent < goal) begin
      kind = $urandom_range(99);
      if (kind < 58) begin
        if (img_rows > 8 || img_width > 12 || $urandom_range(1) == 1) clear_image();
        put_rows($urandom_range(1, 6), $urandom_range(0, 8), $urandom_range(3) == 0);
        read_n(frame_len() * $urandom_range(1, 2) + $urandom_range(0, 2));
      end else if (kind < 72) begin
        if (img_rows > 8 || img_width > 12) clear_image();
        put_rows($urandom_range(1, 4), 6, 1'b0);
        read_n($urandom_range(1, frame_len()));
        put_rows(1, 4, $urandom_range(1) == 1);
        read_n(frame_len());
      end else if (kind < 82) begin
        repeat (8) send(op_t'($urandom_range(3)), rnd_char(), rnd_angle());
      end else if (kind < 90) begin
        clear_image();
        repeat ($urandom_range(0, 2)) send(OP_CLOSE, rnd_char(), rnd_angle());
        read_n($urandom_range(1, 3));
      end else begin
        clear_image();
        if ($urandom_range(1) == 1) begin
          repeat (MAX_COLS + $urandom_range(0, 3)) send(OP_APPEND, rnd_char(), rnd_angle());
          send(OP_CLOSE, rnd_char(), rnd_angle());
        end else begin
          put_rows(MAX_ROWS + $urandom_range(0, 2), 1, $urandom_range(1) == 1);
        end
        read_n(frame_len());
      end
    end
  endtask

  // Output side: random pops, or a long stall when one is asked for.
  initial begin
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (stall_left == 0 && holds_served != hold_asks) begin
        holds_served = hold_asks;
        stall_left   = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_pop <= 1'b0;
      end else begin
        out_pop <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  // Give up when no request moves on either side for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty)) begin
      quiet <= 0;
    end else if (quiet >= WATCHDOG_LIMIT) begin
      $display("%0t ns: timeout, no request moved for %0d cycles", $time, quiet);
      $display("Mismatches found");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // Reset, three idle profiles, drain and verdict.
  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    send_idle = 12;
    recv_idle = 61;
    directed_part();
    random_phase(PHASE_ITEMS);

    send_idle = 61;
    recv_idle = 12;
    random_phase(PHASE_ITEMS);

    send_idle = 0;
    recv_idle = 0;
    random_phase(PHASE_ITEMS);

    in_push <= 1'b0;
    @(posedge clk);
    while (awaited != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d requests (%0d reads) under three idle profiles with long output stalls.",
             n_sent, n_reads);
    $display("Checked %0d read results over all turns, empty and overflowing images.", checked);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
